### sv/dld_pkg.sv
// Package with shared constants, types and helpers for the landmark dedup core.
package dld_pkg;
    localparam int MaxLandmarks = 64;
    localparam int IdxW = $clog2(MaxLandmarks);
    localparam int CntW = $clog2(MaxLandmarks + 1);
    localparam int PosW = 24;
    localparam int PointW = 3 * PosW;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_CLASS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RANGE, ST_COEF, ST_CSUM, ST_ROT, ST_WORLD,
        ST_SCAN, ST_DIFF, ST_SQR, ST_CMP, ST_DONE
    } state_t;

    typedef struct packed {
        logic [PosW-1:0] x;
        logic [PosW-1:0] y;
        logic [PosW-1:0] z;
    } point_t;

    function automatic logic signed [PosW-1:0] sat24(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        begin
            hi = 40'sd8388607;
            lo = -40'sd8388608;
            if (v > hi) begin
                sat24 = 24'sh7FFFFF;
            end else if (v < lo) begin
                sat24 = 24'sh800000;
            end else begin
                sat24 = v[PosW-1:0];
            end
        end
    endfunction
endpackage

### sv/dld_ram.sv
// Generic single-port RAM with a registered read.
module dld_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/detection_landmark_dedup_core.sv
// Landmark dedup core: projects one detection to a world point and appends new landmarks.
// Accepted items scan the stored landmarks (at most 64), each entry taking a read, difference,
// square and compare; a rejected item goes straight to the result.
// One item at a time; the input reopens after the result register is loaded, and a finished
// item waits only while the last result is held.
// Synchronous active-low reset clears count, class and control regs; radius resets to 1280.
module detection_landmark_dedup_core
    import dld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_class_id,
    input  logic [10:0]        s_score,
    input  logic [11:0]        s_pix_width,
    input  logic signed [23:0] s_pos_x,
    input  logic signed [23:0] s_pos_y,
    input  logic signed [23:0] s_pos_z,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic               m_is_new,
    output logic               m_table_full,
    output logic signed [23:0] m_world_x,
    output logic signed [23:0] m_world_y,
    output logic signed [23:0] m_world_z,
    output logic [6:0]         m_landmark_count
);
    state_t state_reg, state_next;
    logic [15:0] radius_reg;
    logic [7:0] class_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] scan_reg;
    logic acc_reg;
    logic signed [23:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [11:0] pix_reg;
    logic signed [17:0] range_reg;
    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [50:0] ox_reg, oy_reg, oz_reg;
    logic signed [23:0] wx_reg, wy_reg, wz_reg;
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic [49:0] sx_reg, sy_reg, sz_reg;
    logic [31:0] r2_reg;
    logic near_reg;
    logic out_valid_reg;
    logic out_acc_reg, out_new_reg, out_full_reg;
    logic signed [23:0] out_x_reg, out_y_reg, out_z_reg;
    logic [6:0] out_cnt_reg;

    logic ram_we;
    logic [IdxW-1:0] ram_addr;
    point_t ram_wdata, ram_rdata;
    logic [16:0] rng_prod;
    logic signed [39:0] tx, ty, tz;
    logic [51:0] d2;
    logic in_fire, scan_end, done_go;

    dld_ram #(.Width(PointW), .Depth(MaxLandmarks)) u_store (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign done_go = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    assign scan_end = (scan_reg >= count_reg);
    // Divide by ten via reciprocal: floor(v/10) = (v*838861)>>23 for v < 2^22.
    assign rng_prod = 17'((40'({pix_reg, 8'd0} + 20'd5) * 40'd838861) >> 23);
    assign tx = 40'(ox_reg + 51'sd134217728 >>> 28) + 40'(px_reg);
    assign ty = 40'(oy_reg + 51'sd134217728 >>> 28) + 40'(py_reg);
    assign tz = 40'(oz_reg + 51'sd134217728 >>> 28) + 40'(pz_reg);
    assign d2 = 52'(sx_reg) + 52'(sy_reg) + 52'(sz_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_RANGE;
            ST_RANGE: state_next = acc_reg ? ST_COEF : ST_DONE;
            ST_COEF:  state_next = ST_CSUM;
            ST_CSUM:  state_next = ST_ROT;
            ST_ROT:   state_next = ST_WORLD;
            ST_WORLD: state_next = ST_SCAN;
            ST_SCAN:  state_next = (scan_end || near_reg) ? ST_DONE : ST_DIFF;
            ST_DIFF:  state_next = ST_SQR;
            ST_SQR:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_SCAN;
            ST_DONE:  state_next = done_go ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we = 1'b0;
        ram_addr = scan_reg[IdxW-1:0];
        ram_wdata = '{x: wx_reg, y: wy_reg, z: wz_reg};
        if (done_go && acc_reg && !near_reg
                && count_reg < CntW'(MaxLandmarks)) begin
            ram_we = 1'b1;
            ram_addr = count_reg[IdxW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            radius_reg <= 16'd1280;
            class_reg <= 8'd0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_RADIUS: radius_reg <= cfg_wdata;
                    CFG_CLASS:  class_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (done_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we) count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                acc_reg <= (s_class_id == class_reg) && (s_score > 11'd512);
                pix_reg <= s_pix_width;
                px_reg <= s_pos_x; py_reg <= s_pos_y; pz_reg <= s_pos_z;
                qx_reg <= s_quat_x; qy_reg <= s_quat_y;
                qz_reg <= s_quat_z; qw_reg <= s_quat_w;
                near_reg <= 1'b0;
                scan_reg <= '0;
                wx_reg <= '0; wy_reg <= '0; wz_reg <= '0;
            end
            ST_RANGE: begin
                range_reg <= 18'sd16384 - $signed({1'b0, rng_prod});
                r2_reg <= radius_reg * radius_reg;
            end
            ST_COEF: begin
                p0_reg <= qx_reg * qz_reg; p1_reg <= qw_reg * qy_reg;
                p2_reg <= qy_reg * qz_reg; p3_reg <= qw_reg * qx_reg;
                p4_reg <= qx_reg * qx_reg; p5_reg <= qy_reg * qy_reg;
            end
            ST_CSUM: begin
                cx_reg <= (34'(p0_reg) + 34'(p1_reg)) <<< 1;
                cy_reg <= (34'(p2_reg) - 34'(p3_reg)) <<< 1;
                cz_reg <= 34'sd268435456 - ((34'(p4_reg) + 34'(p5_reg)) <<< 1);
            end
            ST_ROT: begin
                ox_reg <= 51'(cx_reg) * 51'(range_reg);
                oy_reg <= 51'(cy_reg) * 51'(range_reg);
                oz_reg <= 51'(cz_reg) * 51'(range_reg);
            end
            ST_WORLD: begin
                wx_reg <= sat24(tx); wy_reg <= sat24(ty); wz_reg <= sat24(tz);
            end
            ST_DIFF: begin
                dx_reg <= 25'(wx_reg) - 25'($signed(ram_rdata.x));
                dy_reg <= 25'(wy_reg) - 25'($signed(ram_rdata.y));
                dz_reg <= 25'(wz_reg) - 25'($signed(ram_rdata.z));
            end
            ST_SQR: begin
                sx_reg <= 50'(dx_reg * dx_reg);
                sy_reg <= 50'(dy_reg * dy_reg);
                sz_reg <= 50'(dz_reg * dz_reg);
            end
            ST_CMP: begin
                near_reg <= d2 < 52'(r2_reg);
                scan_reg <= scan_reg + 1'b1;
            end
            ST_DONE: begin
                if (done_go) begin
                    out_acc_reg <= acc_reg;
                    out_new_reg <= ram_we;
                    out_full_reg <= acc_reg && !near_reg && !ram_we;
                    out_x_reg <= wx_reg; out_y_reg <= wy_reg; out_z_reg <= wz_reg;
                    out_cnt_reg <= 7'(ram_we ? count_reg + 1'b1 : count_reg);
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_accepted = out_acc_reg;
    assign m_is_new = out_new_reg;
    assign m_table_full = out_full_reg;
    assign m_world_x = out_x_reg;
    assign m_world_y = out_y_reg;
    assign m_world_z = out_z_reg;
    assign m_landmark_count = out_cnt_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxLandmarks)) else $error("landmark count overflow");
    a_new_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_new && m_table_full)) else $error("new and full together");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("input taken while busy");
endmodule
